// ----- src/mck_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mck_pkg
// Types, register indexes and the character-to-pattern table of the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DOT   = 3'd1,
        PH_DASH  = 3'd2,
        PH_SPACE = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    localparam logic [1:0] EL_DOT   = 2'd1;
    localparam logic [1:0] EL_DASH  = 2'd2;
    localparam logic [1:0] EL_SPACE = 2'd3;

    localparam logic [1:0] CFG_DOT   = 2'd0;
    localparam logic [1:0] CFG_DASH  = 2'd1;
    localparam logic [1:0] CFG_SPACE = 2'd2;
    localparam logic [1:0] CFG_GAP   = 2'd3;

    localparam logic [15:0] DOT_RESET   = 16'd50;
    localparam logic [15:0] DASH_RESET  = 16'd150;
    localparam logic [15:0] SPACE_RESET = 16'd150;
    localparam logic [15:0] GAP_RESET   = 16'd50;

    typedef struct packed {
        logic [11:0] bits;
        logic [2:0]  len;
    } t_pattern;

    // seq lists the elements in sending order, first element in bit len-1,
    // 1 = dash, 0 = dot
    function automatic t_pattern build_pattern(input logic [2:0] len,
                                               input logic [5:0] seq);
        t_pattern p;
        logic [2:0] pos;
        p.bits = '0;
        p.len  = len;
        for (int n = 0; n < 6; n++) begin
            pos = len - 3'(n) - 3'd1;
            if (3'(n) < len) begin
                p.bits[2*n +: 2] = seq[pos] ? EL_DASH : EL_DOT;
            end
        end
        return p;
    endfunction

    function automatic t_pattern char_pattern(input logic [7:0] ch);
        t_pattern   p;
        logic [7:0] uc;
        uc = ch;
        if (ch >= 8'h61 && ch <= 8'h7a) begin
            uc = ch - 8'h20;
        end
        case (uc)
            "A": p = build_pattern(3'd2, 6'b000001);
            "B": p = build_pattern(3'd4, 6'b001000);
            "C": p = build_pattern(3'd4, 6'b001010);
            "D": p = build_pattern(3'd3, 6'b000100);
            "E": p = build_pattern(3'd1, 6'b000000);
            "F": p = build_pattern(3'd4, 6'b000010);
            "G": p = build_pattern(3'd3, 6'b000110);
            "H": p = build_pattern(3'd4, 6'b000000);
            "I": p = build_pattern(3'd2, 6'b000000);
            "J": p = build_pattern(3'd4, 6'b000111);
            "K": p = build_pattern(3'd3, 6'b000101);
            "L": p = build_pattern(3'd4, 6'b000100);
            "M": p = build_pattern(3'd2, 6'b000011);
            "N": p = build_pattern(3'd2, 6'b000010);
            "O": p = build_pattern(3'd3, 6'b000111);
            "P": p = build_pattern(3'd4, 6'b000110);
            "Q": p = build_pattern(3'd4, 6'b001101);
            "R": p = build_pattern(3'd3, 6'b000010);
            "S": p = build_pattern(3'd3, 6'b000000);
            "T": p = build_pattern(3'd1, 6'b000001);
            "U": p = build_pattern(3'd3, 6'b000001);
            "V": p = build_pattern(3'd4, 6'b000001);
            "W": p = build_pattern(3'd3, 6'b000011);
            "X": p = build_pattern(3'd4, 6'b001001);
            "Y": p = build_pattern(3'd4, 6'b001011);
            "Z": p = build_pattern(3'd4, 6'b001100);
            "0": p = build_pattern(3'd5, 6'b011111);
            "1": p = build_pattern(3'd5, 6'b001111);
            "2": p = build_pattern(3'd5, 6'b000111);
            "3": p = build_pattern(3'd5, 6'b000011);
            "4": p = build_pattern(3'd5, 6'b000001);
            "5": p = build_pattern(3'd5, 6'b000000);
            "6": p = build_pattern(3'd5, 6'b010000);
            "7": p = build_pattern(3'd5, 6'b011000);
            "8": p = build_pattern(3'd5, 6'b011100);
            "9": p = build_pattern(3'd5, 6'b011110);
            "?": p = build_pattern(3'd6, 6'b001100);
            ",": p = build_pattern(3'd6, 6'b110011);
            ":": p = build_pattern(3'd6, 6'b111000);
            ".": p = build_pattern(3'd6, 6'b010101);
            "$": p = build_pattern(3'd6, 6'b011010);
            "-": p = build_pattern(3'd6, 6'b100001);
            " ": begin
                p.bits = {10'd0, EL_SPACE};
                p.len  = 3'd1;
            end
            default: begin
                p.bits = '0;
                p.len  = 3'd0;
            end
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- src/morse_code_keyer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// morse_code_keyer
// An accepted request's result lands in the output register at the next edge.
// Throughput: one request per cycle while the output register is free or
// m_tready is high, set by the read-modify-write around the message memory
// (read data prefetched and forwarded). Reset (synchronous, active low) clears
// control state and loads the default durations; the message memory is not cleared.
// ----------------------------------------------------------------------------
module morse_code_keyer #(
    parameter int MESSAGE_DEPTH = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] key_on, [1] done_res, [2] load_refused
);

    localparam int AW = $clog2(MESSAGE_DEPTH);
    localparam int CW = $clog2(MESSAGE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(MESSAGE_DEPTH);

    logic [7:0] mem [MESSAGE_DEPTH];
    logic [7:0] r_rd_data;

    logic [15:0] r_dot, r_dash, r_space, r_gap;

    mck_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_elapsed, n_elapsed;
    logic [11:0]     r_pattern, n_pattern;
    logic [2:0]      r_len, n_len;
    logic [2:0]      r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_out_valid;
    logic [2:0]      r_out;

    logic              accept;
    logic              wr_en;
    logic [15:0]       dur;
    logic [15:0]       inc;
    logic [1:0]        elem;
    logic              done;
    logic              refused;
    mck_pkg::t_pattern lookup;

    assign s_tready = i_rst_n && (!r_out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && s_tuser && (r_count < DEPTH_C);
    assign lookup   = mck_pkg::char_pattern(r_rd_data);

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_pattern = r_pattern;
        n_len     = r_len;
        n_idx     = r_idx;
        n_count   = r_count;
        n_pos     = r_pos;
        refused   = 1'b0;
        dur       = r_gap;
        inc       = '0;
        elem      = '0;
        done      = 1'b0;
        case (r_phase)
            mck_pkg::PH_DOT:   dur = r_dot;
            mck_pkg::PH_DASH:  dur = r_dash;
            mck_pkg::PH_SPACE: dur = r_space;
            default:           dur = r_gap;
        endcase
        if (accept) begin
            if (s_tuser) begin
                if (r_count < DEPTH_C) begin
                    n_count = r_count + CW'(1);
                end else begin
                    refused = 1'b1;
                end
            end else begin
                if (r_phase != mck_pkg::PH_IDLE) begin
                    inc       = (r_elapsed == 16'hffff) ? r_elapsed : r_elapsed + 16'd1;
                    n_elapsed = inc;
                    if (inc >= dur) begin
                        n_elapsed = '0;
                        n_phase   = (r_phase == mck_pkg::PH_GAP) ? mck_pkg::PH_IDLE
                                                                 : mck_pkg::PH_GAP;
                    end
                end
                if (n_phase == mck_pkg::PH_IDLE) begin
                    if (r_idx < r_len) begin
                        elem      = r_pattern[{r_idx, 1'b0} +: 2];
                        n_idx     = r_idx + 3'd1;
                        n_elapsed = '0;
                        case (elem)
                            mck_pkg::EL_DOT:  n_phase = mck_pkg::PH_DOT;
                            mck_pkg::EL_DASH: n_phase = mck_pkg::PH_DASH;
                            default:          n_phase = mck_pkg::PH_SPACE;
                        endcase
                    end else if (r_pos < r_count) begin
                        n_pattern = lookup.bits;
                        n_len     = lookup.len;
                        n_idx     = '0;
                        n_pos     = r_pos + CW'(1);
                        n_elapsed = '0;
                        n_phase   = mck_pkg::PH_SPACE;
                    end else begin
                        n_len = '0;
                        n_idx = '0;
                    end
                end
                if (n_phase == mck_pkg::PH_IDLE && n_pos >= n_count && n_idx >= n_len) begin
                    n_count = '0;
                    n_pos   = '0;
                end
            end
        end
        done = (n_phase == mck_pkg::PH_IDLE) && (n_pos >= n_count) && (n_idx >= n_len);
    end

    // message memory; read data tracks the next read position, with bypass
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= s_tdata;
        end
        if (wr_en && (r_count[AW-1:0] == n_pos[AW-1:0])) begin
            r_rd_data <= s_tdata;
        end else begin
            r_rd_data <= mem[n_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= mck_pkg::DOT_RESET;
            r_dash  <= mck_pkg::DASH_RESET;
            r_space <= mck_pkg::SPACE_RESET;
            r_gap   <= mck_pkg::GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mck_pkg::CFG_DOT:   r_dot   <= i_cfg_data;
                mck_pkg::CFG_DASH:  r_dash  <= i_cfg_data;
                mck_pkg::CFG_SPACE: r_space <= i_cfg_data;
                mck_pkg::CFG_GAP:   r_gap   <= i_cfg_data;
                default:            r_gap   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mck_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_pattern   <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_pattern <= n_pattern;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_pos     <= n_pos;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= {refused, done,
                      (n_phase == mck_pkg::PH_DOT) || (n_phase == mck_pkg::PH_DASH)};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out};

endmodule
`default_nettype wire
